// ----- hdl/mma_pkg.sv -----
// shared types, constants, microcode table and helpers for the matrix multiply-accumulate block
package mma_pkg;

	localparam int MAX_DIM   = 8;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int DATA_W    = 32;
	localparam int DIM_W     = 4;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = 2 * DATA_W;
	// sum of MAX_DIM truncated products plus a 32-bit start value, with headroom
	localparam int ACC_W     = PROD_W - FRAC_W + $clog2(MAX_DIM) + 1;
	localparam int UPC_W     = 3;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

	typedef enum logic [1:0] {
		KIND_LOAD_A  = 2'd0,
		KIND_LOAD_B  = 2'd1,
		KIND_LOAD_C  = 2'd2,
		KIND_COMPUTE = 2'd3
	} kind_t;

	// sequencer branch conditions
	typedef enum logic [2:0] {
		COND_NEXT,
		COND_JUMP,
		COND_WAIT_CMD,
		COND_K_MORE,
		COND_WAIT_OUT
	} cond_t;

	// microprogram step addresses
	localparam logic [UPC_W-1:0] STEP_IDLE   = 3'd0;
	localparam logic [UPC_W-1:0] STEP_RD_C   = 3'd1;
	localparam logic [UPC_W-1:0] STEP_LD_ACC = 3'd2;
	localparam logic [UPC_W-1:0] STEP_RD_AB  = 3'd3;
	localparam logic [UPC_W-1:0] STEP_MUL    = 3'd4;
	localparam logic [UPC_W-1:0] STEP_ADD    = 3'd5;
	localparam logic [UPC_W-1:0] STEP_EMIT   = 3'd6;
	localparam logic [UPC_W-1:0] STEP_LOOP   = 3'd7;

	typedef struct packed {
		logic               idle;
		logic               rd_c;
		logic               ld_acc;
		logic               rd_ab;
		logic               mul;
		logic               add;
		logic               emit;
		cond_t              cond;
		logic [UPC_W-1:0]   target;
	} mma_ctrl_t;

	typedef struct packed {
		logic cmd_go;
		logic k_more;
		logic last_elem;
		logic out_free;
	} mma_stat_t;

	// control store
	function automatic mma_ctrl_t ucode(input logic [UPC_W-1:0] upc);
		mma_ctrl_t w;
		w = '0;
		w.cond = COND_NEXT;
		w.target = STEP_IDLE;
		case (upc)
			STEP_IDLE: begin
				w.idle = 1'b1;
				w.cond = COND_WAIT_CMD;
			end
			STEP_RD_C: begin
				w.rd_c = 1'b1;
			end
			STEP_LD_ACC: begin
				w.ld_acc = 1'b1;
			end
			STEP_RD_AB: begin
				w.rd_ab = 1'b1;
			end
			STEP_MUL: begin
				w.mul = 1'b1;
			end
			STEP_ADD: begin
				w.add = 1'b1;
				w.cond = COND_K_MORE;
				w.target = STEP_RD_AB;
			end
			STEP_EMIT: begin
				w.emit = 1'b1;
				w.cond = COND_WAIT_OUT;
				w.target = STEP_IDLE;
			end
			STEP_LOOP: begin
				w.cond = COND_JUMP;
				w.target = STEP_RD_C;
			end
			default: begin
				w.cond = COND_JUMP;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	// last valid index for a dimension register; zero acts as one, above MAX_DIM as MAX_DIM
	function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
		logic [IDX_W-1:0] l;
		if (d == '0) begin
			l = '0;
		end else if (d > DIM_W'(MAX_DIM)) begin
			l = IDX_W'(MAX_DIM - 1);
		end else begin
			l = IDX_W'(d - DIM_W'(1));
		end
		return l;
	endfunction

endpackage

// ----- hdl/mma_ram.sv -----
// generic single-write, single-read ram with registered read data
module mma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/mma_seq.sv -----
// microcode sequencer: step counter, control store lookup and branch logic
module mma_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  mma_pkg::mma_stat_t  stat,
	output mma_pkg::mma_ctrl_t  ctrl
);

	logic [mma_pkg::UPC_W-1:0] upc_q;
	logic [mma_pkg::UPC_W-1:0] upc_next;
	logic [mma_pkg::UPC_W-1:0] upc_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= mma_pkg::STEP_IDLE;
		end else begin
			upc_q <= upc_next;
		end
	end

	always_comb begin
		ctrl = mma_pkg::ucode(upc_q);
		upc_inc = upc_q + mma_pkg::UPC_W'(1);
		case (ctrl.cond)
			mma_pkg::COND_NEXT:     upc_next = upc_inc;
			mma_pkg::COND_JUMP:     upc_next = ctrl.target;
			mma_pkg::COND_WAIT_CMD: upc_next = stat.cmd_go ? upc_inc : upc_q;
			mma_pkg::COND_K_MORE:   upc_next = stat.k_more ? ctrl.target : upc_inc;
			mma_pkg::COND_WAIT_OUT: begin
				if (!stat.out_free) begin
					upc_next = upc_q;
				end else if (stat.last_elem) begin
					upc_next = ctrl.target;
				end else begin
					upc_next = upc_inc;
				end
			end
			default: upc_next = mma_pkg::STEP_IDLE;
		endcase
	end

endmodule

// ----- hdl/mma_dp.sv -----
// datapath: element stores, index counters, multiplier, accumulator, saturation, output register
module mma_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mma_pkg::mma_ctrl_t                ctrl,
	output mma_pkg::mma_stat_t                stat,
	input  logic [mma_pkg::DIM_W-1:0]         rows_a,
	input  logic [mma_pkg::DIM_W-1:0]         inner_dim,
	input  logic [mma_pkg::DIM_W-1:0]         cols_b,
	input  logic                              in_valid,
	input  mma_pkg::kind_t                    kind,
	input  logic [mma_pkg::IDX_W-1:0]         row,
	input  logic [mma_pkg::IDX_W-1:0]         col,
	input  logic [mma_pkg::DATA_W-1:0]        value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [mma_pkg::IDX_W-1:0]         out_row,
	output logic [mma_pkg::IDX_W-1:0]         out_col,
	output logic [mma_pkg::DATA_W-1:0]        out_value,
	output logic                              saturated,
	output logic                              last
);

	logic [mma_pkg::IDX_W-1:0]  nr_last, nk_last, nc_last;
	logic [mma_pkg::IDX_W-1:0]  r_q, c_q, k_q;
	logic                       load_go, cmd_go, out_free, emit_go, last_elem;
	logic                       a_we, b_we, c_we;
	logic [mma_pkg::ADDR_W-1:0] ld_addr, rc_addr, rk_addr, kc_addr, c_waddr;
	logic [mma_pkg::DATA_W-1:0] a_rd, b_rd, c_rd, c_wdata;
	logic [mma_pkg::DEPTH-1:0]  c_vld_q;
	logic                       c_hit_q;
	logic signed [mma_pkg::PROD_W-1:0] prod_q;
	logic signed [mma_pkg::ACC_W-1:0]  acc_q;
	logic                       sat;
	logic [mma_pkg::DATA_W-1:0] sat_val;
	logic                       out_vld_q;
	logic [mma_pkg::IDX_W-1:0]  out_row_q, out_col_q;
	logic [mma_pkg::DATA_W-1:0] out_value_q;
	logic                       out_sat_q, out_last_q;

	assign nr_last = mma_pkg::dim_last(rows_a);
	assign nk_last = mma_pkg::dim_last(inner_dim);
	assign nc_last = mma_pkg::dim_last(cols_b);

	assign load_go   = ctrl.idle && in_valid && (kind != mma_pkg::KIND_COMPUTE);
	assign cmd_go    = ctrl.idle && in_valid && (kind == mma_pkg::KIND_COMPUTE);
	assign out_free  = !out_vld_q || out_ready;
	assign emit_go   = ctrl.emit && out_free;
	assign last_elem = (r_q == nr_last) && (c_q == nc_last);

	assign stat.cmd_go    = cmd_go;
	assign stat.k_more    = (k_q != nk_last);
	assign stat.last_elem = last_elem;
	assign stat.out_free  = out_free;

	assign ld_addr = {row, col};
	assign rc_addr = {r_q, c_q};
	assign rk_addr = {r_q, k_q};
	assign kc_addr = {k_q, c_q};

	assign a_we = load_go && (kind == mma_pkg::KIND_LOAD_A);
	assign b_we = load_go && (kind == mma_pkg::KIND_LOAD_B);
	assign c_we = (load_go && (kind == mma_pkg::KIND_LOAD_C)) || emit_go;
	assign c_waddr = ctrl.emit ? rc_addr : ld_addr;
	assign c_wdata = ctrl.emit ? sat_val : value;

	mma_ram #(.WIDTH(mma_pkg::DATA_W), .DEPTH(mma_pkg::DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (ld_addr),
		.wdata (value),
		.re    (ctrl.rd_ab),
		.raddr (rk_addr),
		.rdata (a_rd)
	);

	mma_ram #(.WIDTH(mma_pkg::DATA_W), .DEPTH(mma_pkg::DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (ld_addr),
		.wdata (value),
		.re    (ctrl.rd_ab),
		.raddr (kc_addr),
		.rdata (b_rd)
	);

	mma_ram #(.WIDTH(mma_pkg::DATA_W), .DEPTH(mma_pkg::DEPTH)) u_ram_c (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (ctrl.rd_c),
		.raddr (rc_addr),
		.rdata (c_rd)
	);

	// written flags for the c store; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_vld_q <= '0;
		end else if (c_we) begin
			c_vld_q[c_waddr] <= 1'b1;
		end
	end

	// loop indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd_go) begin
				r_q <= '0;
				c_q <= '0;
			end else if (emit_go) begin
				if (c_q == nc_last) begin
					c_q <= '0;
					r_q <= r_q + mma_pkg::IDX_W'(1);
				end else begin
					c_q <= c_q + mma_pkg::IDX_W'(1);
				end
			end
			if (ctrl.rd_c) begin
				k_q <= '0;
			end else if (ctrl.add) begin
				k_q <= k_q + mma_pkg::IDX_W'(1);
			end
		end
	end

	// multiply and accumulate
	always_ff @(posedge clk) begin
		if (ctrl.rd_c) begin
			c_hit_q <= c_vld_q[rc_addr];
		end
		if (ctrl.mul) begin
			prod_q <= mma_pkg::PROD_W'($signed(a_rd)) * mma_pkg::PROD_W'($signed(b_rd));
		end
		if (ctrl.ld_acc) begin
			acc_q <= c_hit_q ? mma_pkg::ACC_W'($signed(c_rd)) : '0;
		end else if (ctrl.add) begin
			acc_q <= acc_q + mma_pkg::ACC_W'(prod_q >>> mma_pkg::FRAC_W);
		end
	end

	// clip the wide sum to 32 bits
	always_comb begin
		sat = (acc_q[mma_pkg::ACC_W-1:mma_pkg::DATA_W-1]
			!= {(mma_pkg::ACC_W - mma_pkg::DATA_W + 1){acc_q[mma_pkg::ACC_W-1]}});
		if (!sat) begin
			sat_val = acc_q[mma_pkg::DATA_W-1:0];
		end else if (acc_q[mma_pkg::ACC_W-1]) begin
			sat_val = {1'b1, {(mma_pkg::DATA_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(mma_pkg::DATA_W-1){1'b1}}};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_go) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_row_q   <= r_q;
			out_col_q   <= c_q;
			out_value_q <= sat_val;
			out_sat_q   <= sat;
			out_last_q  <= last_elem;
		end
	end

	assign out_valid = out_vld_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign saturated = out_sat_q;
	assign last      = out_last_q;

endmodule

// ----- hdl/matrix_multiply_accumulate_top.sv -----
// top level of the matrix multiply-accumulate block, C += A * B in signed Q16.16
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: row, col, value; tuser: kind
// m_axis    out  m_axis_tvalid/tready    tdata: out_row, out_col, out_value; tuser: saturated;
//                                        tlast: last
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data (rows_a, inner_dim, cols_b)
//
// a load word (kind A, B or C) is taken in the idle step and writes one store entry
// a compute word runs rows*cols elements, each through rd_c, ld_acc, then rd_ab, mul and add
//   once per inner index, then emit and loop; the last element goes from emit back to idle
//   instead of looping back; paced by the single shared multiplier and the one read port of each
//   store; input is held off until the last element has been handed to the output register
// a full output register that is not drained holds the sequencer in its emit step
// reset clears the step counter, the indexes, the output valid and the written flags of
//   the c store (unwritten c entries read as zero); there is no clearing pass
module matrix_multiply_accumulate_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // row[2:0], col[5:3], value[37:6], zero pad
	input  logic [1:0]  s_axis_tuser,   // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], out_value[37:6], zero pad
	output logic [0:0]  m_axis_tuser,   // saturated[0]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	mma_pkg::mma_ctrl_t             ctrl;
	mma_pkg::mma_stat_t             stat;
	logic [mma_pkg::DIM_W-1:0]      rows_a_q, inner_dim_q, cols_b_q;
	logic [mma_pkg::IDX_W-1:0]      out_row, out_col;
	logic [mma_pkg::DATA_W-1:0]     out_value;
	logic                           saturated;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= mma_pkg::DIM_W'(mma_pkg::MAX_DIM);
			inner_dim_q <= mma_pkg::DIM_W'(mma_pkg::MAX_DIM);
			cols_b_q    <= mma_pkg::DIM_W'(mma_pkg::MAX_DIM);
		end else if (cfg_valid) begin
			case (cfg_index)
				mma_pkg::CFG_ROWS_A:    rows_a_q    <= cfg_data;
				mma_pkg::CFG_INNER_DIM: inner_dim_q <= cfg_data;
				mma_pkg::CFG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;   // unknown index is dropped
			endcase
		end
	end

	// input words are taken only while the sequencer sits in its idle step
	assign s_axis_tready = ctrl.idle;

	mma_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	mma_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.rows_a    (rows_a_q),
		.inner_dim (inner_dim_q),
		.cols_b    (cols_b_q),
		.in_valid  (s_axis_tvalid),
		.kind      (mma_pkg::kind_t'(s_axis_tuser)),
		.row       (s_axis_tdata[2:0]),
		.col       (s_axis_tdata[5:3]),
		.value     (s_axis_tdata[37:6]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_value (out_value),
		.saturated (saturated),
		.last      (m_axis_tlast)
	);

	// result word packing
	assign m_axis_tdata = {2'b00, out_value, out_col, out_row};
	assign m_axis_tuser = saturated;

endmodule

// ----- hdl/mma_chk.sv -----
// port-level checker for the matrix multiply-accumulate top, bound to it
module mma_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [0:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);

	// stalled result word stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	// stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// a compute word closes the input until its run is done
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == mma_pkg::KIND_COMPUTE
			|=> !s_axis_tready)
		else $error("input open right after a compute word");

	// a load word never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser != mma_pkg::KIND_COMPUTE
			|=> !$rose(m_axis_tvalid))
		else $error("result appeared after a load word");

endmodule

bind matrix_multiply_accumulate_top mma_chk u_mma_chk (.*);
